FILE: src/e1n_pkg.sv
// ============================================================================
// e1n_pkg
// Shared constants and the scale table for the negative-range expm1 pipeline.
// ============================================================================
package e1n_pkg;

    // Pipeline depth of one fused multiply-add unit.
    localparam int FMA_LAT = 7;

    // Binary32 field constants.
    localparam logic [31:0] K_ABS_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] K_EXP_INF   = 32'h7F80_0000;
    localparam logic [31:0] K_QUIET     = 32'h0040_0000;
    localparam logic [31:0] K_DFLT_NAN  = 32'hFFC0_0000;

    // Algorithm constants.
    localparam logic [31:0] K_CUTOFF    = 32'hC18A_A123;
    localparam logic [31:0] K_MAGIC     = 32'h49C0_0000;
    localparam logic [31:0] K_NEG_MAGIC = 32'hC9C0_0000;
    localparam logic [31:0] K_LOG2E     = 32'h3FB8_AA3B;
    localparam logic [31:0] K_MLN2      = 32'hBF31_7218;
    localparam logic [31:0] K_C4        = 32'h3D2A_AC76;
    localparam logic [31:0] K_C3        = 32'h3E2A_AE10;
    localparam logic [31:0] K_C2        = 32'h3F00_0000;
    localparam logic [31:0] K_ONE       = 32'h3F80_0000;
    localparam logic [31:0] K_NEG_ONE   = 32'hBF80_0000;
    localparam logic [31:0] K_NEG_ZERO  = 32'h8000_0000;

    // Fractional powers of two, indexed by the low three bits of the biased n.
    function automatic logic [31:0] scale_lut(input logic [2:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                3'd0:    v = 32'h3F80_0000;
                3'd1:    v = 32'h3F7B_95C2;
                3'd2:    v = 32'h3F78_37F0;
                3'd3:    v = 32'h3F75_FED7;
                3'd4:    v = 32'h3F75_04F3;
                3'd5:    v = 32'h3F75_672A;
                3'd6:    v = 32'h3F77_44FD;
                3'd7:    v = 32'h3F7A_C0C7;
                default: v = 32'h3F80_0000;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/e1n_fma.sv
// ============================================================================
// e1n_fma
// Pipelined binary32 fused multiply-add, a*b+c with one round to nearest even.
// Stages: decode, multiply, align, add, leading-one, shift, round and pack.
// ============================================================================
module e1n_fma
    import e1n_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_r
);

    // Count of leading zeros in a 24-bit significand.
    function automatic logic [4:0] lzc24(input logic [23:0] m);
        logic [4:0] n;
        begin
            n = 5'd0;
            for (int i = 0; i < 24; i++) begin
                if (m[i]) begin
                    n = 5'(23 - i);
                end
            end
            return n;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: decode, special operands, normalize a and b.
    // ------------------------------------------------------------------
    logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
    logic        p_sign;
    logic        n_spec;
    logic [31:0] n_sval;
    logic [23:0] ma0, mb0;
    logic [4:0]  lza, lzb;
    logic [7:0]  ea_eff, eb_eff, ec_eff;

    logic        r1_spec, r1_sp, r1_sc, r1_cz;
    logic [31:0] r1_sval;
    logic [23:0] r1_ma, r1_mb, r1_mc;
    logic signed [10:0] r1_ea, r1_eb, r1_ec;

    always_comb begin
        a_nan  = (i_a & K_ABS_MASK) > K_EXP_INF;
        b_nan  = (i_b & K_ABS_MASK) > K_EXP_INF;
        c_nan  = (i_c & K_ABS_MASK) > K_EXP_INF;
        a_inf  = (i_a & K_ABS_MASK) == K_EXP_INF;
        b_inf  = (i_b & K_ABS_MASK) == K_EXP_INF;
        c_inf  = (i_c & K_ABS_MASK) == K_EXP_INF;
        a_zero = i_a[30:0] == 31'd0;
        b_zero = i_b[30:0] == 31'd0;
        c_zero = i_c[30:0] == 31'd0;
        p_sign = i_a[31] ^ i_b[31];

        n_spec = 1'b1;
        n_sval = 32'd0;
        if (a_nan) begin
            n_sval = i_a | K_QUIET;
        end else if (b_nan) begin
            n_sval = i_b | K_QUIET;
        end else if (c_nan) begin
            n_sval = i_c | K_QUIET;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            n_sval = K_DFLT_NAN;
        end else if (a_inf || b_inf) begin
            if (c_inf && (i_c[31] != p_sign)) begin
                n_sval = K_DFLT_NAN;
            end else begin
                n_sval = {p_sign, K_EXP_INF[30:0]};
            end
        end else if (c_inf) begin
            n_sval = i_c;
        end else if (a_zero || b_zero) begin
            // A zero product leaves c exact; two zeros keep a sign only if both agree.
            n_sval = c_zero ? {p_sign & i_c[31], 31'd0} : i_c;
        end else begin
            n_spec = 1'b0;
        end

        ea_eff = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb_eff = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ec_eff = (i_c[30:23] == 8'd0) ? 8'd1 : i_c[30:23];
        ma0    = {i_a[30:23] != 8'd0, i_a[22:0]};
        mb0    = {i_b[30:23] != 8'd0, i_b[22:0]};
        lza    = lzc24(ma0);
        lzb    = lzc24(mb0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_spec <= n_spec;
            r1_sval <= n_sval;
            r1_sp   <= p_sign;
            r1_sc   <= i_c[31];
            r1_cz   <= c_zero;
            r1_ma   <= ma0 << lza;
            r1_mb   <= mb0 << lzb;
            r1_mc   <= {i_c[30:23] != 8'd0, i_c[22:0]};
            r1_ea   <= $signed({3'b000, ea_eff}) - 11'sd150 - $signed({6'd0, lza});
            r1_eb   <= $signed({3'b000, eb_eff}) - 11'sd150 - $signed({6'd0, lzb});
            r1_ec   <= $signed({3'b000, ec_eff}) - 11'sd150;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: significand product and the window position of c.
    // ------------------------------------------------------------------
    logic signed [10:0] w0_s1;
    logic        r2_spec, r2_sp, r2_sc, r2_cz;
    logic [31:0] r2_sval;
    logic [47:0] r2_mp;
    logic [23:0] r2_mc;
    logic signed [10:0] r2_w0, r2_pos, r2_ec;

    assign w0_s1 = r1_ea + r1_eb - 11'sd26;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_spec <= r1_spec;
            r2_sval <= r1_sval;
            r2_sp   <= r1_sp;
            r2_sc   <= r1_sc;
            r2_cz   <= r1_cz;
            r2_mp   <= {24'd0, r1_ma} * {24'd0, r1_mb};
            r2_mc   <= r1_mc;
            r2_w0   <= w0_s1;
            r2_pos  <= r1_ec - w0_s1;
            r2_ec   <= r1_ec;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: place product and c in a 100-bit window.
    // An operand far below the other collapses to a sticky bit at the bottom.
    // ------------------------------------------------------------------
    logic [99:0] n3_p, n3_c;
    logic signed [10:0] n3_w0;
    logic        r3_spec, r3_sp, r3_sc;
    logic [31:0] r3_sval;
    logic [99:0] r3_p, r3_c;
    logic signed [10:0] r3_w0;

    always_comb begin
        n3_p  = {26'd0, r2_mp, 26'd0};
        n3_c  = 100'd0;
        n3_w0 = r2_w0;
        if (r2_cz) begin
            n3_c = 100'd0;
        end else if (r2_pos > 11'sd76) begin
            n3_c  = {r2_mc, 76'd0};
            n3_p  = 100'd1;
            n3_w0 = r2_ec - 11'sd76;
        end else if (r2_pos < 11'sd0) begin
            n3_c = 100'd1;
        end else begin
            n3_c = {76'd0, r2_mc} << r2_pos[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_spec <= r2_spec;
            r3_sval <= r2_sval;
            r3_sp   <= r2_sp;
            r3_sc   <= r2_sc;
            r3_p    <= n3_p;
            r3_c    <= n3_c;
            r3_w0   <= n3_w0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed-magnitude add; exact cancellation gives +0.
    // ------------------------------------------------------------------
    logic [101:0] diff;
    logic [100:0] n4_m;
    logic         n4_sg;
    logic        r4_spec, r4_sg;
    logic [31:0] r4_sval;
    logic [100:0] r4_m;
    logic signed [10:0] r4_w0;

    always_comb begin
        diff = {2'b00, r3_p} - {2'b00, r3_c};
        if (r3_sp == r3_sc) begin
            n4_m  = {1'b0, r3_p} + {1'b0, r3_c};
            n4_sg = r3_sp;
        end else if (diff[101]) begin
            n4_m  = 101'(-diff);
            n4_sg = r3_sc;
        end else begin
            n4_m  = diff[100:0];
            n4_sg = r3_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_spec <= r3_spec;
            r4_sval <= r3_sval;
            r4_m    <= n4_m;
            r4_sg   <= n4_sg;
            r4_w0   <= r3_w0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: leading one, shift amount and exponent with subnormal floor.
    // ------------------------------------------------------------------
    logic [6:0]  lead;
    logic signed [10:0] thr, lead_s, shift;
    logic        r5_spec, r5_sg, r5_z;
    logic [31:0] r5_sval;
    logic [100:0] r5_m;
    logic [6:0]  r5_sh;
    logic [10:0] r5_exp;

    always_comb begin
        lead = 7'd0;
        for (int i = 0; i < 101; i++) begin
            if (r4_m[i]) begin
                lead = 7'(i);
            end
        end
        lead_s = $signed({4'd0, lead});
        thr    = -11'sd126 - r4_w0;
        shift  = (lead_s >= thr) ? lead_s : thr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_spec <= r4_spec;
            r5_sval <= r4_sval;
            r5_sg   <= r4_sg;
            r5_z    <= r4_m == 101'd0;
            r5_m    <= r4_m;
            r5_sh   <= (shift > 11'sd125) ? 7'd125 : shift[6:0];
            r5_exp  <= (lead_s >= thr) ? 11'(lead_s + r4_w0 + 11'sd126) : 11'd0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: extract significand, guard and sticky.
    // ------------------------------------------------------------------
    logic [124:0] yw, tw, mask;
    logic        r6_spec, r6_sg, r6_z, r6_g, r6_st;
    logic [31:0] r6_sval;
    logic [23:0] r6_mant;
    logic [10:0] r6_exp;

    always_comb begin
        yw   = {r5_m, 24'd0};
        tw   = yw >> r5_sh;
        mask = ~({125{1'b1}} << r5_sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_spec <= r5_spec;
            r6_sval <= r5_sval;
            r6_sg   <= r5_sg;
            r6_z    <= r5_z;
            r6_mant <= tw[24:1];
            r6_g    <= tw[0];
            r6_st   <= |(yw & mask);
            r6_exp  <= r5_exp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round to nearest even, pack, saturate to infinity.
    // ------------------------------------------------------------------
    logic        inc;
    logic [24:0] m2;
    logic [33:0] packed_sum;
    logic [30:0] mag;
    logic [31:0] r7_res;

    always_comb begin
        inc        = r6_g & (r6_st | r6_mant[0]);
        m2         = {1'b0, r6_mant} + {24'd0, inc};
        packed_sum = {r6_exp, 23'd0} + {9'd0, m2};
        mag        = (packed_sum >= {2'b00, K_EXP_INF}) ? K_EXP_INF[30:0] : packed_sum[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r6_spec) begin
                r7_res <= r6_sval;
            end else if (r6_z) begin
                r7_res <= 32'd0;
            end else begin
                r7_res <= {r6_sg, mag};
            end
        end
    end

    assign o_r = r7_res;

endmodule

FILE: src/expm1_negative_f32.sv
// ============================================================================
// expm1_negative_f32
// exp(x)-1 in binary32 for x in the negative range: clamp, range reduction,
// table scale, degree-4 polynomial and reconstruction on fused multiply-adds.
// ============================================================================
// Path from input beat to output beat: one clamp stage plus eight dependent
// fused multiply-adds of 7 stages each.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the output beat waits.
// Reset: i_rst_n clears all valid bits; data registers are not reset.
module expm1_negative_f32
    import e1n_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] x_bits
    input  logic        i_s_axis_tlast,   // end_of_batch
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] y_bits
    output logic        o_m_axis_tlast    // end_out
);

    localparam int TOT = 8 * FMA_LAT;

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Valid and frame flag travel alongside the data.
    logic r_vld [0:TOT];
    logic r_eob [0:TOT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= TOT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i <= TOT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eob[0] <= i_s_axis_tlast;
            for (int i = 1; i <= TOT; i++) begin
                r_eob[i] <= r_eob[i-1];
            end
        end
    end

    // Clamp below at the cutoff; NaN passes through.
    logic        x_nan, x_low;
    logic [31:0] r_xc;

    assign x_nan = (i_s_axis_tdata & K_ABS_MASK) > K_EXP_INF;
    assign x_low = i_s_axis_tdata[31] && (i_s_axis_tdata[30:0] > K_CUTOFF[30:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xc <= (!x_nan && x_low) ? K_CUTOFF : i_s_axis_tdata;
        end
    end

    // Arithmetic chain.
    logic [31:0] n0, s_val, nn, tt, sm1, p1, p2, p3, ts, p4, ff;
    logic [31:0] r_xd  [0:13];
    logic [31:0] r_sd  [0:13];
    logic [31:0] r_td  [0:13];
    logic [31:0] r_qd  [0:13];
    logic [31:0] r_md  [0:34];

    assign s_val = scale_lut(n0[2:0]) + (n0 << 20);

    e1n_fma u_n0  (.i_clk(i_clk), .i_en(en), .i_a(r_xc), .i_b(K_LOG2E), .i_c(K_MAGIC),
                   .o_r(n0));
    e1n_fma u_n   (.i_clk(i_clk), .i_en(en), .i_a(n0), .i_b(K_ONE), .i_c(K_NEG_MAGIC),
                   .o_r(nn));
    e1n_fma u_sm1 (.i_clk(i_clk), .i_en(en), .i_a(s_val), .i_b(K_ONE), .i_c(K_NEG_ONE),
                   .o_r(sm1));
    e1n_fma u_t   (.i_clk(i_clk), .i_en(en), .i_a(nn), .i_b(K_MLN2), .i_c(r_xd[13]),
                   .o_r(tt));
    e1n_fma u_p1  (.i_clk(i_clk), .i_en(en), .i_a(K_C4), .i_b(tt), .i_c(K_C3),
                   .o_r(p1));
    e1n_fma u_ts  (.i_clk(i_clk), .i_en(en), .i_a(tt), .i_b(r_sd[13]), .i_c(K_NEG_ZERO),
                   .o_r(ts));
    e1n_fma u_p2  (.i_clk(i_clk), .i_en(en), .i_a(p1), .i_b(r_td[6]), .i_c(K_C2),
                   .o_r(p2));
    e1n_fma u_p3  (.i_clk(i_clk), .i_en(en), .i_a(p2), .i_b(r_td[13]), .i_c(K_NEG_ZERO),
                   .o_r(p3));
    e1n_fma u_p4  (.i_clk(i_clk), .i_en(en), .i_a(p3), .i_b(r_qd[13]), .i_c(r_qd[13]),
                   .o_r(p4));
    e1n_fma u_f   (.i_clk(i_clk), .i_en(en), .i_a(p4), .i_b(K_ONE), .i_c(r_md[34]),
                   .o_r(ff));

    // Delay lines that keep operands aligned with the chain.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd[0] <= r_xc;
            r_sd[0] <= s_val;
            r_td[0] <= tt;
            r_qd[0] <= ts;
            r_md[0] <= sm1;
            for (int i = 1; i < 14; i++) begin
                r_xd[i] <= r_xd[i-1];
                r_sd[i] <= r_sd[i-1];
                r_td[i] <= r_td[i-1];
                r_qd[i] <= r_qd[i-1];
            end
            for (int i = 1; i < 35; i++) begin
                r_md[i] <= r_md[i-1];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[TOT];
    assign o_m_axis_tlast  = r_eob[TOT];
    assign o_m_axis_tdata  = ff;

endmodule

FILE: tb/sv/expm1_negative_f32_tb.sv
// ============================================================================
// expm1_negative_f32_tb
// Self-checking bench for the binary32 exp(x)-1 pipeline. A bit-exact software
// predictor computes each expected beat. The driver sends beats in random
// bursts. The receiver stalls on its own pattern. A monitor compares every
// output beat in order.
// ============================================================================
`timescale 1ns / 1ps

module expm1_negative_f32_tb
    import e1n_pkg::*;
();

    typedef struct packed {
        logic [31:0] x;
        logic        last;
    } t_x_beat;

    typedef struct packed {
        logic [31:0] y;
        logic        last;
    } t_y_beat;

    localparam int RANDOM_ITEMS = 1030;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int PAUSE_AT     = 350;
    localparam int HOLD_AT      = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] x_bits
    logic        i_s_axis_tlast;   // end_of_batch
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] y_bits
    logic        o_m_axis_tlast;   // end_out

    t_x_beat x_pending[$];
    t_y_beat expm1_expected[$];
    bit      fill_done;
    int      fail_cnt;
    int      sent_cnt;
    int      recv_cnt;
    int      idle_cycles;
    int      gap_left;
    int      burst_left;
    int      hold_left;
    int      stall_mode;
    int      mode_left;
    bit      long_hold_done;
    bit      beat_open;

    expm1_negative_f32 i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Binary32 arithmetic on top of binary64 reals.
    // ------------------------------------------------------------------
    function automatic bit f32_is_nan(input logic [31:0] b);
        return (b & K_ABS_MASK) > K_EXP_INF;
    endfunction

    function automatic bit f32_is_inf(input logic [31:0] b);
        return (b & K_ABS_MASK) == K_EXP_INF;
    endfunction

    function automatic real f32_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF) begin
            return $bitstoreal({b[31], 11'h7FF, 52'd0});
        end
        if (b[30:0] == 31'd0) begin
            return $bitstoreal({b[31], 63'd0});
        end
        if (b[30:23] == 8'd0) begin
            // Subnormal: mantissa times 2^-149 is exact in binary64.
            r = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0});
    endfunction

    // One round-to-nearest-even step from binary64 to binary32.
    function automatic logic [31:0] real_to_f32(input real d);
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        b = $realtobits(d);
        if (b[62:52] == 11'h7FF) begin
            if (b[51:0] != 52'd0) return K_DFLT_NAN;
            return {b[63], 8'hFF, 23'd0};
        end
        if (b[62:52] == 11'd0) return {b[63], 31'd0};
        e  = int'(b[62:52]) - 1023;
        m  = {11'd0, 1'b1, b[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 62) sh = 62;
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        if (e >= -126) begin
            if (q[24]) begin
                q = q >> 1;
                e = e + 1;
            end
            if (e > 127) return {b[63], 8'hFF, 23'd0};
            return {b[63], 8'(e + 127), q[22:0]};
        end
        // A carry into bit 23 lands on the smallest normal by itself.
        return {b[63], q[30:0]};
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        if (f32_is_nan(a)) return a | K_QUIET;
        if (f32_is_nan(b)) return b | K_QUIET;
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
        if (f32_is_nan(a)) return a | K_QUIET;
        if (f32_is_nan(b)) return b | K_QUIET;
        return real_to_f32(f32_to_real(a) - f32_to_real(b));
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        if (f32_is_nan(a)) return a | K_QUIET;
        if (f32_is_nan(b)) return b | K_QUIET;
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    // Fused a*b+c: exact product, two-sum error, round to odd, then one rounding.
    function automatic logic [31:0] f32_fma(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
        bit          a_zero;
        bit          b_zero;
        logic        psign;
        real         p;
        real         cd;
        real         s;
        real         bv;
        real         err;
        logic [63:0] sb;
        a_zero = (a & K_ABS_MASK) == 0;
        b_zero = (b & K_ABS_MASK) == 0;
        if (f32_is_nan(a)) return a | K_QUIET;
        if (f32_is_nan(b)) return b | K_QUIET;
        if (f32_is_nan(c)) return c | K_QUIET;
        if ((f32_is_inf(a) && b_zero) || (f32_is_inf(b) && a_zero)) return K_DFLT_NAN;
        if (f32_is_inf(a) || f32_is_inf(b)) begin
            psign = a[31] ^ b[31];
            if (f32_is_inf(c) && c[31] != psign) return K_DFLT_NAN;
            return {psign, 31'd0} | K_EXP_INF;
        end
        if (f32_is_inf(c)) return c;
        p   = f32_to_real(a) * f32_to_real(b);
        cd  = f32_to_real(c);
        s   = p + cd;
        bv  = s - p;
        err = (p - (s - bv)) + (cd - bv);
        if (err != 0.0) begin
            sb = $realtobits(s);
            if (!sb[0]) begin
                if ((err > 0.0) == (s > 0.0)) sb = sb + 64'd1;
                else sb = sb - 64'd1;
                s = $bitstoreal(sb);
            end
        end
        return real_to_f32(s);
    endfunction

    // Full exp(x)-1 sequence for one element.
    function automatic logic [31:0] expm1_predict(input logic [31:0] x_in);
        logic [31:0] x;
        logic [31:0] n0;
        logic [31:0] sc;
        logic [31:0] n;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] ts;
        logic [31:0] sm1;
        x = x_in;
        if (!f32_is_nan(x) && f32_to_real(x) < f32_to_real(K_CUTOFF)) x = K_CUTOFF;
        n0  = f32_fma(x, K_LOG2E, K_MAGIC);
        sc  = scale_lut(n0[2:0]) + (n0 << 20);
        n   = f32_sub(n0, K_MAGIC);
        t   = f32_fma(n, K_MLN2, x);
        p   = f32_fma(K_C4, t, K_C3);
        p   = f32_fma(p, t, K_C2);
        p   = f32_mul(p, t);
        ts  = f32_mul(t, sc);
        sm1 = f32_sub(sc, K_ONE);
        p   = f32_fma(p, ts, ts);
        return f32_add(p, sm1);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corner values, then mostly in-range random values.
    // ------------------------------------------------------------------
    function automatic logic [31:0] in_range_value();
        logic [31:0] v;
        // Negative, exponents from tiny up to the cutoff region.
        v = {1'b1, 8'($urandom_range(90, 131)), 23'($urandom)};
        return v;
    endfunction

    initial begin
        logic [31:0] directed[$];
        logic [31:0] v;
        int          k;
        fill_done = 1'b0;
        directed = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'hBF00_0000,
                     32'hC000_0000, 32'hC18A_A123, 32'hC18A_A122, 32'hC18A_A124,
                     32'hC1A0_0000, 32'hFF80_0000, 32'h7F80_0000, 32'h7FC0_0000,
                     32'h7F80_0001, 32'hFFFF_FFFF, 32'hFF80_0001, 32'h3F80_0000,
                     32'h42C8_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h8000_0001,
                     32'h807F_FFFF, 32'h0000_0001, 32'hB300_0000, 32'hC17F_FFFF};
        foreach (directed[i]) x_pending.push_back('{x: directed[i], last: i[0]});
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    v = $urandom;
                2:       v = {1'b0, 8'($urandom_range(90, 133)), 23'($urandom)};
                default: v = in_range_value();
            endcase
            x_pending.push_back('{x: v, last: ($urandom_range(0, 7) == 0)});
        end
        fill_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: bursts and gaps, one pause that drains the pipeline.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tlast  <= 1'b0;
            gap_left        <= 0;
            burst_left      <= 0;
        end else if (beat_open) begin
            // Beat still waiting for ready: keep it as is.
        end else if (sent_cnt == PAUSE_AT && expm1_expected.size() != 0) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left        <= gap_left - 1;
        end else if (x_pending.size() != 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= x_pending[0].x;
            i_s_axis_tlast  <= x_pending[0].last;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall modes that change over time, plus one long hold-off.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= 0;
            stall_mode      <= 0;
            mode_left       <= 0;
            long_hold_done  <= 1'b0;
        end else if (!long_hold_done && recv_cnt >= HOLD_AT) begin
            long_hold_done  <= 1'b1;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       i_m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: record accepted inputs, check accepted outputs.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_y_beat want;
        bit      moved;
        if (!i_rst_n) begin
            sent_cnt    <= 0;
            recv_cnt    <= 0;
            idle_cycles <= 0;
            beat_open   <= 1'b0;
        end else begin
            moved = 1'b0;
            beat_open <= i_s_axis_tvalid && !o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                moved = 1'b1;
                expm1_expected.push_back('{y: expm1_predict(i_s_axis_tdata),
                                          last: i_s_axis_tlast});
                void'(x_pending.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                moved = 1'b1;
                recv_cnt <= recv_cnt + 1;
                if (expm1_expected.size() == 0) begin
                    $error("output beat with nothing expected: y_bits=%h", o_m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = expm1_expected.pop_front();
                    if (o_m_axis_tdata !== want.y) begin
                        $error("y_bits mismatch: expected %h, actual %h",
                               want.y, o_m_axis_tdata);
                        fail_cnt++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("end_out mismatch: expected %0d, actual %0d",
                               want.last, o_m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // End of run and watchdog.
    // ------------------------------------------------------------------
    initial begin
        fail_cnt = 0;
        wait (i_rst_n === 1'b1 && fill_done);
        while (x_pending.size() != 0 || expm1_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (120) @(posedge i_clk);
        if (expm1_expected.size() != 0) fail_cnt++;
        if (fail_cnt == 0) begin
            $display("expm1_negative_f32 verification clean");
        end else begin
            $display("expm1_negative_f32 verification failed");
        end
        $finish;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        wait (idle_cycles >= IDLE_LIMIT);
        $display("expm1_negative_f32 verification failed");
        $finish;
    end

endmodule
